>>> sv/csev_pkg.sv
// ----------------------------------------------------------------------------
// csev_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, saturating add and product rounding for the
// Chebyshev series evaluator.
// ----------------------------------------------------------------------------
package csev_pkg;

  // Table depth and derived address width
  localparam int MAX_TERMS = 512;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // Field widths
  localparam int CIDX_W    = 9;   // coef_index field
  localparam int COEF_W    = 48;  // Q15.32 coefficient and result
  localparam int SAMPLE_W  = 32;  // Q16.16 sample and center
  localparam int CFG_W     = 32;  // configuration data
  localparam int CFG_IDX_W = 2;   // configuration register index
  localparam int DEG_W     = 9;   // degree register
  localparam int ACC_W     = 64;  // Q31.32 working width
  localparam int WIDE_W    = 128; // full product width

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 2'd0,
    REG_SCALE  = 2'd1,
    REG_DEGREE = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] SCALE_RST = 32'h4000_0000;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] OUT_MIN = 64'shFFFF_8000_0000_0000;
  localparam logic signed [ACC_W:0]   MAX65   = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W:0]   MIN65   = 65'sh1_8000_0000_0000_0001;

  // Rounding offsets: half an LSB of Q.32 after the product, and of the
  // Q.32 normalized sample after the Q.46 scale product
  localparam logic [WIDE_W-1:0] RND_Q32 = 128'h8000_0000;
  localparam logic [ACC_W:0]    RND_T   = 65'h2000;

  // Value with a clamp flag
  typedef struct packed {
    logic signed [ACC_W-1:0] v;
    logic                    sat;
  } sval_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             start;
    logic             load_wr;
    logic             diff;
    logic             t_mul;
    logic             t_fin;
    logic             mset;
    logic             op_coef;
    logic             mul_go;
    logic [1:0]       mul_pair;
    logic             m_fin;
    logic             dbl;
    logic             sub;
    logic             acc_add;
    logic             out_load;
    logic [IDX_W-1:0] rd_addr;
  } csev_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } csev_sts_t;

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] n;
    n = -a;
    return a[ACC_W-1] ? n : a;
  endfunction

  // Add, clamping to +-(2^63-1)
  function automatic sval_t sadd(input logic signed [ACC_W-1:0] a,
                                 input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    sval_t r;
    s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
    if (s > MAX65) begin
      r.v   = SAT_MAX;
      r.sat = 1'b1;
    end else if (s < MIN65) begin
      r.v   = -SAT_MAX;
      r.sat = 1'b1;
    end else begin
      r.v   = $signed(s[ACC_W-1:0]);
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Take a rounded magnitude product to Q.32, clamp and apply the sign
  function automatic sval_t mulq_fin(input logic [WIDE_W-1:0] w, input logic neg);
    logic [ACC_W-1:0] m;
    sval_t r;
    if ((|w[127:96]) || w[95]) begin
      m     = SAT_MAX;
      r.sat = 1'b1;
    end else begin
      m     = w[95:32];
      r.sat = 1'b0;
    end
    r.v = neg ? -$signed(m) : $signed(m);
    return r;
  endfunction

endpackage

>>> sv/csev_ifs.sv
// ----------------------------------------------------------------------------
// csev interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface csev_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic [csev_pkg::CIDX_W-1:0]          coef_index;
  logic signed [csev_pkg::COEF_W-1:0]   coef_value;
  logic signed [csev_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, mode, coef_index, coef_value, sample, input ready);
  modport sink   (input valid, mode, coef_index, coef_value, sample, output ready);
endinterface

interface csev_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [csev_pkg::COEF_W-1:0] value;
  logic                               out_of_interval;
  logic                               saturated;

  modport source (output valid, value, out_of_interval, saturated, input ready);
  modport sink   (input valid, value, out_of_interval, saturated, output ready);
endinterface

interface csev_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csev_pkg::CFG_IDX_W-1:0] index;
  logic [csev_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/csev_cfg.sv
// ----------------------------------------------------------------------------
// csev_cfg: configuration registers
// Holds center, scale and degree; every write transaction is taken at once.
// ----------------------------------------------------------------------------
module csev_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  csev_cfg_if.sink                             cfg,
  output logic signed [csev_pkg::SAMPLE_W-1:0] center,
  output logic [csev_pkg::CFG_W-1:0]           scale,
  output logic [csev_pkg::DEG_W-1:0]           degree
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      scale  <= csev_pkg::SCALE_RST;
      degree <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        csev_pkg::REG_CENTER: center <= $signed(cfg.data[csev_pkg::SAMPLE_W-1:0]);
        csev_pkg::REG_SCALE:  scale  <= cfg.data;
        csev_pkg::REG_DEGREE: degree <= cfg.data[csev_pkg::DEG_W-1:0];
        default: ; // drop writes to unknown registers
      endcase
    end
  end

endmodule

>>> sv/csev_ctrl.sv
// ----------------------------------------------------------------------------
// csev_ctrl: evaluation sequencer
// Steps the datapath through normalization, the term recurrence and the
// four partial products of each shared-multiplier product.
// ----------------------------------------------------------------------------
module csev_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_mode,
  output logic                           in_ready,
  input  logic [csev_pkg::DEG_W-1:0]     degree,
  input  csev_pkg::csev_sts_t            sts,
  output csev_pkg::csev_cmd_t            cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_TMUL,
    ST_TFIN,
    ST_MSET,
    ST_MPP,
    ST_MFIN,
    ST_DBL,
    ST_SUB,
    ST_ACC,
    ST_DONE
  } state_t;

  localparam logic [2:0] PP_LAST = 3'd4;

  state_t                     state;
  logic [csev_pkg::IDX_W-1:0] k;
  logic [2:0]                 step;
  logic                       op_coef;
  logic [csev_pkg::IDX_W-1:0] deg_eff;

  // Highest term index, limited to the table
  always_comb begin
    if (32'(degree) > csev_pkg::MAX_TERMS - 1) begin
      deg_eff = csev_pkg::IDX_W'(csev_pkg::MAX_TERMS - 1);
    end else begin
      deg_eff = csev_pkg::IDX_W'(degree);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      k       <= '0;
      step    <= '0;
      op_coef <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && (in_mode == csev_pkg::MODE_EVAL)) begin
            k     <= '0;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_TMUL;
        ST_TMUL: begin
          // advance the read address so coef[1] is ready at the first setup
          k     <= csev_pkg::IDX_W'(1);
          state <= ST_TFIN;
        end
        ST_TFIN: begin
          op_coef <= 1'b1;
          state   <= (deg_eff == '0) ? ST_DONE : ST_MSET;
        end
        ST_MSET: begin
          step  <= '0;
          state <= ST_MPP;
        end
        ST_MPP: begin
          if (step == PP_LAST) begin
            state <= ST_MFIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_MFIN: state <= op_coef ? ST_ACC : ST_DBL;
        ST_DBL:  state <= ST_SUB;
        ST_SUB: begin
          op_coef <= 1'b1;
          state   <= ST_MSET;
        end
        ST_ACC: begin
          if (k == deg_eff) begin
            state <= ST_DONE;
          end else begin
            k       <= k + csev_pkg::IDX_W'(1);
            op_coef <= 1'b0;
            state   <= ST_MSET;
          end
        end
        ST_DONE: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = k;
    cmd.op_coef = op_coef;
    in_ready    = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.start   = in_valid && (in_mode == csev_pkg::MODE_EVAL);
        cmd.load_wr = in_valid && (in_mode == csev_pkg::MODE_LOAD);
      end
      ST_DIFF: cmd.diff  = 1'b1;
      ST_TMUL: cmd.t_mul = 1'b1;
      ST_TFIN: cmd.t_fin = 1'b1;
      ST_MSET: cmd.mset  = 1'b1;
      ST_MPP: begin
        cmd.mul_go   = (step != PP_LAST);
        cmd.mul_pair = step[1:0];
      end
      ST_MFIN: cmd.m_fin    = 1'b1;
      ST_DBL:  cmd.dbl      = 1'b1;
      ST_SUB:  cmd.sub      = 1'b1;
      ST_ACC:  cmd.acc_add  = 1'b1;
      ST_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> sv/csev_dp.sv
// ----------------------------------------------------------------------------
// csev_dp: evaluation datapath
// Coefficient memory, shared 32x32 multiplier with 128-bit accumulator,
// recurrence registers and the output register.
// ----------------------------------------------------------------------------
module csev_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csev_pkg::csev_cmd_t                  cmd,
  output csev_pkg::csev_sts_t                  sts,
  input  logic signed [csev_pkg::SAMPLE_W-1:0] center,
  input  logic [csev_pkg::CFG_W-1:0]           scale,
  input  logic [csev_pkg::CIDX_W-1:0]          coef_index,
  input  logic signed [csev_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [csev_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [csev_pkg::COEF_W-1:0]   out_value,
  output logic                                 out_oor,
  output logic                                 out_sat
);

  localparam int AW = csev_pkg::ACC_W;
  localparam int CW = csev_pkg::COEF_W;

  // Coefficient memory
  logic signed [CW-1:0]          mem [csev_pkg::MAX_TERMS];
  logic signed [CW-1:0]          rdata;
  logic                          ld_ok;
  logic [csev_pkg::IDX_W-1:0]    ld_addr;

  // Normalization
  logic signed [csev_pkg::SAMPLE_W-1:0] samp;
  logic signed [csev_pkg::SAMPLE_W:0]   diff_v;
  logic signed [csev_pkg::SAMPLE_W:0]   diff_n;
  logic                                 dneg;
  logic [csev_pkg::SAMPLE_W-1:0]        dmag;
  logic [AW:0]                          t_sum;
  logic [AW-1:0]                        t_mag;
  logic signed [AW-1:0]                 t_val;
  logic signed [AW-1:0]                 t;
  logic                                 oor;

  // Shared multiplier
  logic [AW-1:0]             ma, mb;
  logic                      mneg;
  logic [31:0]               mx, my;
  logic [AW-1:0]             pp;
  logic                      pp_vld;
  logic [1:0]                pp_sh;
  logic [csev_pkg::WIDE_W-1:0] pp_wide;
  logic [csev_pkg::WIDE_W-1:0] wacc;
  logic signed [AW-1:0]      op_a;

  // Recurrence
  logic signed [AW-1:0] mres, nxt, cur, prev, acc;
  logic                 sat;
  csev_pkg::sval_t      r_mul, r_dbl, r_sub, r_acc;

  // First coefficient halved
  logic [CW-1:0]        c0_mag;
  logic [CW-1:0]        c0_h;
  logic signed [AW-1:0] c0_val;

  // Output clamp
  logic signed [AW-1:0] o_val;
  logic                 o_clip;

  assign ld_ok   = 32'(coef_index) < csev_pkg::MAX_TERMS;
  assign ld_addr = csev_pkg::IDX_W'(coef_index);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && ld_ok) begin
      mem[ld_addr] <= coef_value;
    end
    rdata <= mem[cmd.rd_addr];
  end

  always_comb begin
    diff_v = $signed({samp[csev_pkg::SAMPLE_W-1], samp})
           - $signed({center[csev_pkg::SAMPLE_W-1], center});
    diff_n = -diff_v;
    t_sum  = {1'b0, pp} + csev_pkg::RND_T;
    t_mag  = AW'(t_sum[AW:14]);
    t_val  = dneg ? -$signed(t_mag) : $signed(t_mag);

    c0_mag = rdata[CW-1] ? CW'(-rdata) : CW'(rdata);
    c0_h   = CW'(({1'b0, c0_mag} + {{CW{1'b0}}, 1'b1}) >> 1);
    c0_val = rdata[CW-1] ? -$signed(AW'(c0_h)) : $signed(AW'(c0_h));

    op_a   = cmd.op_coef ? AW'(rdata) : t;

    mx     = cmd.t_mul ? dmag : (cmd.mul_pair[1] ? ma[63:32] : ma[31:0]);
    my     = cmd.t_mul ? scale : (cmd.mul_pair[0] ? mb[63:32] : mb[31:0]);

    case (pp_sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      2'd2:    pp_wide = {pp, 64'd0};
      default: pp_wide = '0;
    endcase

    r_mul = csev_pkg::mulq_fin(wacc, mneg);
    r_dbl = csev_pkg::sadd(mres, mres);
    r_sub = csev_pkg::sadd(nxt, -prev);
    r_acc = csev_pkg::sadd(acc, mres);

    if (acc > csev_pkg::OUT_MAX) begin
      o_val  = csev_pkg::OUT_MAX;
      o_clip = 1'b1;
    end else if (acc < csev_pkg::OUT_MIN) begin
      o_val  = csev_pkg::OUT_MIN;
      o_clip = 1'b1;
    end else begin
      o_val  = acc;
      o_clip = 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      samp <= sample;
    end
    if (cmd.diff) begin
      dneg <= diff_v[csev_pkg::SAMPLE_W];
      dmag <= diff_v[csev_pkg::SAMPLE_W] ? diff_n[csev_pkg::SAMPLE_W-1:0]
                                         : diff_v[csev_pkg::SAMPLE_W-1:0];
    end
    if (cmd.t_mul || cmd.mul_go) begin
      pp    <= mx * my;
      pp_sh <= 2'(cmd.mul_pair[1]) + 2'(cmd.mul_pair[0]);
    end
    if (cmd.mset) begin
      mneg <= op_a[AW-1] ^ cur[AW-1];
      ma   <= csev_pkg::mag64(op_a);
      mb   <= csev_pkg::mag64(cur);
      wacc <= csev_pkg::RND_Q32;
    end else if (pp_vld) begin
      wacc <= wacc + pp_wide;
    end
    if (cmd.t_fin) begin
      t    <= t_val;
      oor  <= t_mag > AW'(csev_pkg::ONE_Q32);
      acc  <= c0_val;
      cur  <= t_val;
      prev <= csev_pkg::ONE_Q32;
      sat  <= 1'b0;
    end
    if (cmd.m_fin) begin
      mres <= r_mul.v;
      sat  <= sat | r_mul.sat;
    end
    if (cmd.dbl) begin
      nxt <= r_dbl.v;
      sat <= sat | r_dbl.sat;
    end
    if (cmd.sub) begin
      cur  <= r_sub.v;
      prev <= cur;
      sat  <= sat | r_sub.sat;
    end
    if (cmd.acc_add) begin
      acc <= r_acc.v;
      sat <= sat | r_acc.sat;
    end
    if (cmd.out_load) begin
      out_value <= o_val[CW-1:0];
      out_oor   <= oor;
      out_sat   <= sat | o_clip;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pp_vld <= cmd.mul_go;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

>>> sv/chebyshev_series_evaluator_top.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_top: Chebyshev series evaluator
// Load items write the memory in the cycle they are accepted. In an evaluate
// item the term k = 1 runs one 64x64 product and every later term runs two,
// all through one shared 32x32 multiplier, four partial products each.
// The next item is accepted from the cycle a result enters the output reg.
// Reset (rst, sync, active high) restores center 0, scale 1.0, degree 0 and
// empties the output register; coefficient memory is not cleared.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator_top (
  input  logic        clk,
  input  logic        rst,
  csev_in_if.sink     item,
  csev_out_if.source  result,
  csev_cfg_if.sink    cfg
);

  // Configuration values
  logic signed [csev_pkg::SAMPLE_W-1:0] center;
  logic [csev_pkg::CFG_W-1:0]           scale;
  logic [csev_pkg::DEG_W-1:0]           degree;

  // Controller/datapath link
  csev_pkg::csev_cmd_t cmd;
  csev_pkg::csev_sts_t sts;

  logic in_ready;

  // Register file: takes every configuration transaction in the cycle it
  // is offered. Writes must arrive only while idle; the block does not check.
  csev_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .center (center),
    .scale  (scale),
    .degree (degree)
  );

  // Sequencer: accepts one item from idle. A load transaction writes the
  // memory in the accepting cycle and the block stays idle. An evaluate
  // transaction runs:
  //   normalize  - subtract center, scale by the shared multiplier, round
  //   first term - coef[0]/2 into the accumulator
  //   each term  - t*T(k-1), double, subtract T(k-2) (k >= 2), times coef[k],
  //                accumulate; all clamps fold into the saturated flag
  //   done       - clamp to Q15.32 and hand over to the output register,
  //                holding while that register still carries a result
  csev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (in_ready),
    .degree   (degree),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign item.ready = in_ready;

  // Datapath: memory, multiplier and recurrence registers. The output
  // register drives the result channel directly and frees up in the same
  // cycle its transaction completes.
  csev_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .center     (center),
    .scale      (scale),
    .coef_index (item.coef_index),
    .coef_value (item.coef_value),
    .sample     (item.sample),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.value),
    .out_oor    (result.out_of_interval),
    .out_sat    (result.saturated)
  );

endmodule
